// File: hdl/bfst_pkg.sv
// ----------------------------------------------------------------------------
// bfst_pkg
// Shared types and constants for the bidirectional flow statistics table.
// ----------------------------------------------------------------------------
package bfst_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;

    localparam int ADDR_W    = 64;
    localparam int PORT_W    = 16;
    localparam int PROTO_W   = 8;
    localparam int BYTES_W   = 16;
    localparam int BITS_W    = 48;
    localparam int PKTS_W    = 32;
    localparam int IVAL_W    = 16;
    localparam int SLOT_W    = 10;
    localparam int HASH_W    = 32;
    localparam int BYTE_SHIFT = 3;  // bits per byte = 8
    localparam int DIV_STEPS = BITS_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [BITS_W-1:0] BITS_MAX = {BITS_W{1'b1}};
    localparam logic [PKTS_W-1:0] PKTS_MAX = {PKTS_W{1'b1}};

    typedef struct packed {
        logic               valid;
        logic               ipv6;
        logic [ADDR_W-1:0]  src_hi;
        logic [ADDR_W-1:0]  src_lo;
        logic [ADDR_W-1:0]  dst_hi;
        logic [ADDR_W-1:0]  dst_lo;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
        logic [PROTO_W-1:0] protocol;
        logic [BITS_W-1:0]  tx_bits;
        logic [PKTS_W-1:0]  tx_pkts;
        logic [BITS_W-1:0]  rx_bits;
        logic [PKTS_W-1:0]  rx_pkts;
    } entry_t;

endpackage

// File: hdl/bidirectional_flow_stats_table_unit.sv
// Flow: from input acceptance to out_valid a counted packet passes through a read
//   and a compare state per way of bucket scan, update, 48-step divider and load;
//   a packet dropped on a full bucket goes from the scan straight to load.
// One packet is in flight at a time; the 48-step divider dominates.
// Clear item: one entry per cycle, then the result is loaded. Reset
//   runs the same sweep before in_ready rises; configuration is taken throughout.
// ----------------------------------------------------------------------------
// bidirectional_flow_stats_table_unit
// Hashed set-associative flow table with per-direction totals and rates.
// ----------------------------------------------------------------------------
module bidirectional_flow_stats_table_unit #(
    parameter int BUCKETS = bfst_pkg::BUCKETS_DEF,
    parameter int WAYS    = bfst_pkg::WAYS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic                         is_ipv6,
    input  logic [bfst_pkg::ADDR_W-1:0]  src_addr_hi,
    input  logic [bfst_pkg::ADDR_W-1:0]  src_addr_lo,
    input  logic [bfst_pkg::ADDR_W-1:0]  dst_addr_hi,
    input  logic [bfst_pkg::ADDR_W-1:0]  dst_addr_lo,
    input  logic [bfst_pkg::PORT_W-1:0]  src_l4_port,
    input  logic [bfst_pkg::PORT_W-1:0]  dst_l4_port,
    input  logic [bfst_pkg::PROTO_W-1:0] protocol,
    input  logic [bfst_pkg::BYTES_W-1:0] packet_bytes,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bfst_pkg::SLOT_W-1:0]  flow_slot,
    output logic                         new_flow,
    output logic                         is_transmit,
    output logic [bfst_pkg::BITS_W-1:0]  tx_bits_total,
    output logic [bfst_pkg::PKTS_W-1:0]  tx_pkt_total,
    output logic [bfst_pkg::BITS_W-1:0]  rx_bits_total,
    output logic [bfst_pkg::PKTS_W-1:0]  rx_pkt_total,
    output logic [bfst_pkg::BITS_W-1:0]  bit_rate,
    output logic [bfst_pkg::PKTS_W-1:0]  packet_rate,
    output logic                         table_full,
    output logic                         clear_done,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bfst_pkg::IVAL_W-1:0]  cfg_data
);

    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BW      = bfst_pkg::BITS_W;
    localparam int PW      = bfst_pkg::PKTS_W;
    localparam int IW      = bfst_pkg::IVAL_W;
    localparam int DCW     = bfst_pkg::DCNT_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    bfst_pkg::entry_t mem [ENTRIES];
    bfst_pkg::entry_t rd_data_reg;
    bfst_pkg::entry_t ent_reg, ent_next;
    bfst_pkg::entry_t ent_upd;
    bfst_pkg::entry_t wr_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_op_reg, clr_op_next;
    logic [IW-1:0]    interval_reg;

    // captured packet, IPv4 already normalized
    logic                         p_v6_reg;
    logic [bfst_pkg::ADDR_W-1:0]  p_shi_reg, p_slo_reg, p_dhi_reg, p_dlo_reg;
    logic [bfst_pkg::PORT_W-1:0]  p_sp_reg, p_dp_reg;
    logic [bfst_pkg::PROTO_W-1:0] p_proto_reg;
    logic [bfst_pkg::BYTES_W-1:0] p_bytes_reg;
    logic [BKT_W-1:0]             bucket_reg;

    logic [WAY_W-1:0] way_reg, way_next;
    logic             found_reg, found_next;
    logic             free_reg, free_next;
    logic [WAY_W-1:0] free_way_reg, free_way_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             fresh_reg, fresh_next;
    logic             full_reg, full_next;
    logic             tx_reg, tx_next;

    logic [BW-1:0]    qb_reg, qb_next;
    logic [BW-1:0]    qp_reg, qp_next;
    logic [IW-1:0]    rb_reg, rb_next;
    logic [IW-1:0]    rp_reg, rp_next;
    logic [DCW-1:0]   dcnt_reg, dcnt_next;

    logic out_valid_reg, out_valid_next;
    logic out_load;

    logic [bfst_pkg::SLOT_W-1:0] flow_slot_reg;
    logic                        new_flow_reg, is_transmit_reg, table_full_reg, clear_done_reg;
    logic [BW-1:0]               tx_bits_reg, rx_bits_reg, bit_rate_reg;
    logic [PW-1:0]               tx_pk_reg, rx_pk_reg, packet_rate_reg;

    // normalized input and hash
    logic [bfst_pkg::ADDR_W-1:0] n_shi, n_slo, n_dhi, n_dlo;
    logic [bfst_pkg::HASH_W-1:0] hash;

    // compare and update datapath
    logic          m_fwd, m_rev, m_hit;
    logic [IDX_W-1:0] base_idx;
    logic          upd_tx;
    logic [BW:0]   bsum;
    logic [BW-1:0] bsat;
    logic [PW:0]   psum;
    logic [PW-1:0] psat;
    logic [BW-1:0] cur_bits;
    logic [PW-1:0] cur_pk;

    logic [IW-1:0] divisor;
    logic [IW:0]   tb, tp;
    logic          gb, gp;

    logic in_acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;

    always_comb
    begin
        n_shi = is_ipv6 ? src_addr_hi : '0;
        n_dhi = is_ipv6 ? dst_addr_hi : '0;
        n_slo = is_ipv6 ? src_addr_lo : {32'd0, src_addr_lo[31:0]};
        n_dlo = is_ipv6 ? dst_addr_lo : {32'd0, dst_addr_lo[31:0]};
        if (is_ipv6)
            hash = {24'd0, src_addr_hi[63:56] ^ dst_addr_hi[63:56]};
        else
            hash = src_addr_lo[31:0] ^ dst_addr_lo[31:0];
        hash = hash ^ {16'd0, src_l4_port ^ dst_l4_port};
    end

    assign base_idx = IDX_W'(bucket_reg) * IDX_W'(WAYS);
    assign rd_addr  = base_idx + IDX_W'(way_reg);

    always_comb
    begin
        m_fwd = rd_data_reg.src_hi == p_shi_reg && rd_data_reg.src_lo == p_slo_reg &&
                rd_data_reg.dst_hi == p_dhi_reg && rd_data_reg.dst_lo == p_dlo_reg &&
                rd_data_reg.sport == p_sp_reg && rd_data_reg.dport == p_dp_reg;
        m_rev = rd_data_reg.src_hi == p_dhi_reg && rd_data_reg.src_lo == p_dlo_reg &&
                rd_data_reg.dst_hi == p_shi_reg && rd_data_reg.dst_lo == p_slo_reg &&
                rd_data_reg.sport == p_dp_reg && rd_data_reg.dport == p_sp_reg;
        m_hit = rd_data_reg.valid && (rd_data_reg.ipv6 == p_v6_reg) && (m_fwd || m_rev);
    end

    // saturating update of the held entry
    always_comb
    begin
        upd_tx   = ent_reg.src_hi == p_shi_reg && ent_reg.src_lo == p_slo_reg &&
                   ent_reg.sport == p_sp_reg;
        cur_bits = upd_tx ? ent_reg.tx_bits : ent_reg.rx_bits;
        cur_pk   = upd_tx ? ent_reg.tx_pkts : ent_reg.rx_pkts;
        bsum     = {1'b0, cur_bits}
                 + (BW+1)'({p_bytes_reg, {bfst_pkg::BYTE_SHIFT{1'b0}}});
        bsat     = bsum[BW] ? bfst_pkg::BITS_MAX : bsum[BW-1:0];
        psum     = {1'b0, cur_pk} + (PW+1)'(1);
        psat     = psum[PW] ? bfst_pkg::PKTS_MAX : psum[PW-1:0];
        ent_upd          = ent_reg;
        ent_upd.protocol = p_proto_reg;
        if (upd_tx)
        begin
            ent_upd.tx_bits = bsat;
            ent_upd.tx_pkts = psat;
        end
        else
        begin
            ent_upd.rx_bits = bsat;
            ent_upd.rx_pkts = psat;
        end
    end

    // one restoring step for each quotient
    always_comb
    begin
        divisor = (interval_reg == '0) ? IW'(1) : interval_reg;
        tb = {rb_reg, qb_reg[BW-1]};
        tp = {rp_reg, qp_reg[BW-1]};
        gb = tb >= {1'b0, divisor};
        gp = tp >= {1'b0, divisor};
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = ent_upd;
        if (state_reg == S_CLR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (state_reg == S_UPD)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_op_next    = clr_op_reg;
        way_next       = way_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        free_way_next  = free_way_reg;
        slot_next      = slot_reg;
        fresh_next     = fresh_reg;
        full_next      = full_reg;
        tx_next        = tx_reg;
        ent_next       = ent_reg;
        qb_next        = qb_reg;
        qp_next        = qp_reg;
        rb_next        = rb_reg;
        rp_next        = rp_reg;
        dcnt_next      = dcnt_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_op_reg ? S_OUT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    clr_op_next   = operation;
                    way_next      = '0;
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    free_way_next = '0;
                    full_next     = 1'b0;
                    state_next    = operation ? S_CLR : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (m_hit && !found_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = rd_addr;
                    ent_next   = rd_data_reg;
                end
                if (!rd_data_reg.valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_way_next = way_reg;
                end
                if (way_reg == WAY_W'(WAYS - 1))
                begin
                    fresh_next = 1'b0;
                    state_next = S_UPD;
                    if (!(found_reg || m_hit))
                    begin
                        fresh_next = 1'b1;
                        if (free_reg || !rd_data_reg.valid)
                        begin
                            slot_next = base_idx +
                                IDX_W'(free_reg ? free_way_reg : way_reg);
                            ent_next        = '0;
                            ent_next.valid  = 1'b1;
                            ent_next.ipv6   = p_v6_reg;
                            ent_next.src_hi = p_shi_reg;
                            ent_next.src_lo = p_slo_reg;
                            ent_next.dst_hi = p_dhi_reg;
                            ent_next.dst_lo = p_dlo_reg;
                            ent_next.sport  = p_sp_reg;
                            ent_next.dport  = p_dp_reg;
                        end
                        else
                        begin
                            full_next  = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                end
                else
                begin
                    way_next   = way_reg + WAY_W'(1);
                    state_next = S_RD;
                end
            end
            S_UPD:
            begin
                ent_next   = ent_upd;
                tx_next    = upd_tx;
                qb_next    = upd_tx ? ent_upd.tx_bits : ent_upd.rx_bits;
                qp_next    = BW'(upd_tx ? ent_upd.tx_pkts : ent_upd.rx_pkts);
                rb_next    = '0;
                rp_next    = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rb_next   = gb ? IW'(tb - {1'b0, divisor}) : tb[IW-1:0];
                rp_next   = gp ? IW'(tp - {1'b0, divisor}) : tp[IW-1:0];
                qb_next   = {qb_reg[BW-2:0], gb};
                qp_next   = {qp_reg[BW-2:0], gp};
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(bfst_pkg::DIV_STEPS - 1))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            clr_op_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            interval_reg  <= IW'(1);
            way_reg       <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            free_way_reg  <= '0;
            full_reg      <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_op_reg    <= clr_op_next;
            out_valid_reg <= out_valid_next;
            way_reg       <= way_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            free_way_reg  <= free_way_next;
            full_reg      <= full_next;
            dcnt_reg      <= dcnt_next;
            if (cfg_valid && cfg_ready)
                interval_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        fresh_reg <= fresh_next;
        tx_reg    <= tx_next;
        ent_reg   <= ent_next;
        qb_reg    <= qb_next;
        qp_reg    <= qp_next;
        rb_reg    <= rb_next;
        rp_reg    <= rp_next;
        if (in_acc)
        begin
            p_v6_reg    <= is_ipv6;
            p_shi_reg   <= n_shi;
            p_slo_reg   <= n_slo;
            p_dhi_reg   <= n_dhi;
            p_dlo_reg   <= n_dlo;
            p_sp_reg    <= src_l4_port;
            p_dp_reg    <= dst_l4_port;
            p_proto_reg <= protocol;
            p_bytes_reg <= packet_bytes;
            bucket_reg  <= hash[BKT_W-1:0];
        end
        if (out_load)
        begin
            // clear and dropped packets report zeros apart from their flag
            if (clr_op_reg || full_reg)
            begin
                flow_slot_reg   <= '0;
                new_flow_reg    <= 1'b0;
                is_transmit_reg <= 1'b0;
                tx_bits_reg     <= '0;
                tx_pk_reg       <= '0;
                rx_bits_reg     <= '0;
                rx_pk_reg       <= '0;
                bit_rate_reg    <= '0;
                packet_rate_reg <= '0;
            end
            else
            begin
                flow_slot_reg   <= bfst_pkg::SLOT_W'(slot_reg);
                new_flow_reg    <= fresh_reg;
                is_transmit_reg <= tx_reg;
                tx_bits_reg     <= ent_reg.tx_bits;
                tx_pk_reg       <= ent_reg.tx_pkts;
                rx_bits_reg     <= ent_reg.rx_bits;
                rx_pk_reg       <= ent_reg.rx_pkts;
                bit_rate_reg    <= qb_reg;
                packet_rate_reg <= qp_reg[PW-1:0];
            end
            table_full_reg <= full_reg && !clr_op_reg;
            clear_done_reg <= clr_op_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign flow_slot     = flow_slot_reg;
    assign new_flow      = new_flow_reg;
    assign is_transmit   = is_transmit_reg;
    assign tx_bits_total = tx_bits_reg;
    assign tx_pkt_total  = tx_pk_reg;
    assign rx_bits_total = rx_bits_reg;
    assign rx_pkt_total  = rx_pk_reg;
    assign bit_rate      = bit_rate_reg;
    assign packet_rate   = packet_rate_reg;
    assign table_full    = table_full_reg;
    assign clear_done    = clear_done_reg;

endmodule
